// ===== rtl/sepia_pkg.sv =====
// Shared types, constants and weight table for the sepia byte stream core.
package sepia_pkg;

   // floor(s / 1000) == (s * 536871) >> 29 for every sum below 2^19.
   localparam int RECIP_SHIFT = 29;

   localparam int BYTE_W     = 8;
   localparam int SIZE_W     = 13;
   localparam int WEIGHT_W   = 10;
   localparam int PROD_W     = WEIGHT_W + BYTE_W;
   localparam int SUM_W      = PROD_W + 1;
   localparam int RECIP_W    = 20;
   localparam int MUL_W      = SUM_W + RECIP_W;
   localparam int QUOT_W     = MUL_W - RECIP_SHIFT;
   localparam int CSR_IDX_W  = 8;
   localparam int CSR_DATA_W = 16;

   localparam logic [RECIP_W-1:0] RECIP_1000 = RECIP_W'(536871);
   localparam logic [BYTE_W-1:0]  BYTE_MAX   = 8'd255;

   localparam logic [SIZE_W-1:0] FRAME_ROWS_RESET = 13'd720;
   localparam logic [SIZE_W-1:0] FRAME_COLS_RESET = 13'd1024;

   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_ROWS = 8'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_COLS = 8'd1;

   typedef enum logic [2:0] {
      CH_BLUE  = 3'b001,
      CH_GREEN = 3'b010,
      CH_RED   = 3'b100
   } channel_type;

   typedef struct packed {
      logic [BYTE_W-1:0] blue;
      logic [BYTE_W-1:0] green;
      logic [BYTE_W-1:0] red;
      logic              frame_end;
   } pixel_type;

   typedef struct packed {
      logic empty;
      logic full;
   } queue_status_type;

   typedef struct packed {
      logic                  valid;
      logic [CSR_IDX_W-1:0]  index;
      logic [CSR_DATA_W-1:0] data;
   } csr_write_type;

   typedef struct packed {
      logic [WEIGHT_W-1:0] w_red;
      logic [WEIGHT_W-1:0] w_green;
      logic [WEIGHT_W-1:0] w_blue;
   } weights_type;

   function automatic weights_type sepia_weights(channel_type chan);
      weights_type w;
      case (chan)
         CH_BLUE:  w = '{w_red: 10'd272, w_green: 10'd534, w_blue: 10'd131};
         CH_GREEN: w = '{w_red: 10'd349, w_green: 10'd686, w_blue: 10'd168};
         CH_RED:   w = '{w_red: 10'd393, w_green: 10'd769, w_blue: 10'd189};
         default:  w = '{w_red: 10'd272, w_green: 10'd534, w_blue: 10'd131};
      endcase
      return w;
   endfunction

endpackage

// ===== rtl/sepia_front.sv =====
// Front end: collects blue, green and red bytes into pixels and tracks frame position.
module sepia_front (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_push,
   output logic                              req_full,
   input  logic [sepia_pkg::BYTE_W-1:0]      req_channel_byte,
   input  sepia_pkg::csr_write_type          csr_wr,
   input  sepia_pkg::queue_status_type       pixq_status,
   output logic                              pixq_push,
   output sepia_pkg::pixel_type              pixq_data
);
   import sepia_pkg::*;

   channel_type       phase_ff, phase_in;
   logic [BYTE_W-1:0] blue_ff, blue_in;
   logic [BYTE_W-1:0] green_ff, green_in;
   logic [SIZE_W-1:0] rows_ff, rows_in;
   logic [SIZE_W-1:0] cols_ff, cols_in;
   logic [SIZE_W-1:0] row_ff, row_in;
   logic [SIZE_W-1:0] col_ff, col_in;

   logic            accept;
   logic [SIZE_W:0] col_next;
   logic [SIZE_W:0] row_next;
   logic            row_done;
   logic            frame_done;
   logic            frame_end;

   // Only a red byte needs room in the pixel queue.
   assign req_full = (phase_ff == CH_RED) && pixq_status.full;
   assign accept   = req_push && !req_full;

   assign col_next   = {1'b0, col_ff} + (SIZE_W+1)'(1);
   assign row_next   = {1'b0, row_ff} + (SIZE_W+1)'(1);
   assign row_done   = col_next >= {1'b0, cols_ff};
   assign frame_done = row_next >= {1'b0, rows_ff};
   assign frame_end  = (rows_ff != '0) && (cols_ff != '0) &&
                       (row_ff == rows_ff - SIZE_W'(1)) && (col_ff == cols_ff - SIZE_W'(1));

   assign pixq_push = accept && (phase_ff == CH_RED);
   assign pixq_data = '{blue: blue_ff, green: green_ff, red: req_channel_byte,
                        frame_end: frame_end};

   always_comb begin
      phase_in = phase_ff;
      blue_in  = blue_ff;
      green_in = green_ff;
      row_in   = row_ff;
      col_in   = col_ff;
      rows_in  = rows_ff;
      cols_in  = cols_ff;
      if (accept) begin
         case (phase_ff)
            CH_GREEN: begin
               green_in = req_channel_byte;
               phase_in = CH_RED;
            end
            CH_RED: begin
               phase_in = CH_BLUE;
               if (row_done) begin
                  col_in = '0;
                  row_in = frame_done ? '0 : row_next[SIZE_W-1:0];
               end else begin
                  col_in = col_next[SIZE_W-1:0];
               end
            end
            default: begin
               blue_in  = req_channel_byte;
               phase_in = CH_GREEN;
            end
         endcase
      end
      if (csr_wr.valid) begin
         if (csr_wr.index == CSR_FRAME_ROWS) begin
            rows_in = csr_wr.data[SIZE_W-1:0];
         end else if (csr_wr.index == CSR_FRAME_COLS) begin
            cols_in = csr_wr.data[SIZE_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= CH_BLUE;
         row_ff   <= '0;
         col_ff   <= '0;
         rows_ff  <= FRAME_ROWS_RESET;
         cols_ff  <= FRAME_COLS_RESET;
      end else begin
         phase_ff <= phase_in;
         row_ff   <= row_in;
         col_ff   <= col_in;
         rows_ff  <= rows_in;
         cols_ff  <= cols_in;
      end
      blue_ff  <= blue_in;
      green_ff <= green_in;
   end

endmodule

// ===== rtl/sepia_pixq.sv =====
// Four-entry pixel queue between the front end and the arithmetic back end.
module sepia_pixq (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        push,
   input  sepia_pkg::pixel_type        push_data,
   input  logic                        pop,
   output sepia_pkg::pixel_type        head,
   output sepia_pkg::queue_status_type status
);
   import sepia_pkg::*;

   localparam int DEPTH = 4;
   localparam int PTR_W = $clog2(DEPTH);

   pixel_type        entry_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [PTR_W:0]   count_ff, count_in;
   logic             do_push;
   logic             do_pop;

   assign status.empty = (count_ff == '0);
   assign status.full  = (count_ff == (PTR_W+1)'(DEPTH));
   assign head         = entry_ff[rd_ptr_ff];

   assign do_push = push && !status.full;
   assign do_pop  = pop && !status.empty;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop  ? rd_ptr_ff + PTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff + (PTR_W+1)'(do_push) - (PTR_W+1)'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ===== rtl/sepia_back.sv =====
// Back end: per-channel weighted sum, divide by 1000, saturate, and result queue.
module sepia_back (
   input  logic                         clock,
   input  logic                         reset,
   input  sepia_pkg::pixel_type         pixq_head,
   input  sepia_pkg::queue_status_type  pixq_status,
   output logic                         pixq_pop,
   output logic                         rsp_empty,
   input  logic                         rsp_pop,
   output logic [sepia_pkg::BYTE_W-1:0] rsp_out_byte,
   output logic                         rsp_run_end,
   output logic                         rsp_frame_end
);
   import sepia_pkg::*;

   localparam int DEPTH = 8;
   localparam int PTR_W = $clog2(DEPTH);

   typedef struct packed {
      logic [BYTE_W-1:0] out_byte;
      logic              run_end;
      logic              frame_end;
   } result_type;

   channel_type       chan_ff, chan_in;
   weights_type       weights;
   logic              issue;
   logic [PTR_W+1:0]  committed;

   logic              s1_valid_ff;
   logic [PROD_W-1:0] s1_prod_r_ff, s1_prod_g_ff, s1_prod_b_ff;
   logic              s1_last_ff, s1_fend_ff;

   logic              s2_valid_ff;
   logic [SUM_W-1:0]  s2_sum_ff;
   logic              s2_last_ff, s2_fend_ff;

   logic              s3_valid_ff;
   logic [MUL_W-1:0]  s3_mul_ff;
   logic              s3_last_ff, s3_fend_ff;

   logic [QUOT_W-1:0] quotient;
   result_type        result;

   result_type        entry_ff [DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [PTR_W:0]    count_ff, count_in;
   logic              do_pop;

   // Requests in the pipeline hold a reserved slot, so the queue never overflows.
   assign committed = (PTR_W+2)'(count_ff) + (PTR_W+2)'(s1_valid_ff)
                    + (PTR_W+2)'(s2_valid_ff) + (PTR_W+2)'(s3_valid_ff);
   assign issue     = !pixq_status.empty && (committed < (PTR_W+2)'(DEPTH));
   assign pixq_pop  = issue && (chan_ff == CH_RED);
   assign weights   = sepia_weights(chan_ff);

   always_comb begin
      chan_in = chan_ff;
      if (issue) begin
         case (chan_ff)
            CH_BLUE:  chan_in = CH_GREEN;
            CH_GREEN: chan_in = CH_RED;
            default:  chan_in = CH_BLUE;
         endcase
      end
   end

   assign quotient = s3_mul_ff[MUL_W-1:RECIP_SHIFT];
   assign result.out_byte  = (quotient > QUOT_W'(BYTE_MAX)) ? BYTE_MAX : quotient[BYTE_W-1:0];
   assign result.run_end   = s3_last_ff;
   assign result.frame_end = s3_fend_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         chan_ff     <= CH_BLUE;
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else begin
         chan_ff     <= chan_in;
         s1_valid_ff <= issue;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
      end
      s1_prod_r_ff <= PROD_W'(weights.w_red)   * PROD_W'(pixq_head.red);
      s1_prod_g_ff <= PROD_W'(weights.w_green) * PROD_W'(pixq_head.green);
      s1_prod_b_ff <= PROD_W'(weights.w_blue)  * PROD_W'(pixq_head.blue);
      s1_last_ff   <= (chan_ff == CH_RED);
      s1_fend_ff   <= (chan_ff == CH_RED) && pixq_head.frame_end;
      s2_sum_ff    <= SUM_W'(s1_prod_r_ff) + SUM_W'(s1_prod_g_ff) + SUM_W'(s1_prod_b_ff);
      s2_last_ff   <= s1_last_ff;
      s2_fend_ff   <= s1_fend_ff;
      s3_mul_ff    <= MUL_W'(s2_sum_ff) * MUL_W'(RECIP_1000);
      s3_last_ff   <= s2_last_ff;
      s3_fend_ff   <= s2_fend_ff;
   end

   assign rsp_empty     = (count_ff == '0);
   assign rsp_out_byte  = entry_ff[rd_ptr_ff].out_byte;
   assign rsp_run_end   = entry_ff[rd_ptr_ff].run_end;
   assign rsp_frame_end = entry_ff[rd_ptr_ff].frame_end;
   assign do_pop        = rsp_pop && !rsp_empty;

   always_comb begin
      wr_ptr_in = s3_valid_ff ? wr_ptr_ff + PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + PTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff + (PTR_W+1)'(s3_valid_ff) - (PTR_W+1)'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (s3_valid_ff) begin
         entry_ff[wr_ptr_ff] <= result;
      end
   end

endmodule

// ===== rtl/sepia_tone_byte_stream_core.sv =====
// Top level of the sepia tone byte stream core.
//
//   channel   direction  ports                                        accepted when
//   req       in         req_push, req_full, req_channel_byte         push && !full
//   rsp       out        rsp_pop, rsp_empty, rsp_out_byte,
//                        rsp_run_end, rsp_frame_end                   pop && !empty
//   csr       in         csr_valid, csr_ready, csr_index, csr_data    valid && ready
//
// One input byte is taken per cycle while req_full is low, and three result bytes leave per
// pixel at one per cycle while rsp_empty is low and rsp_pop is high. Each pixel goes through
// the pixel queue, the product, sum and reciprocal multiply stages and the eight-entry result
// queue to rsp. Reset is synchronous; frame size returns to 720 rows by 1024 columns.
// req_full rises only on a red byte when the four-pixel queue is full; the back end stops
// issuing when the result queue plus requests in flight would exceed eight entries.
module sepia_tone_byte_stream_core (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_push,
   output logic                             req_full,
   input  logic [sepia_pkg::BYTE_W-1:0]     req_channel_byte,
   output logic                             rsp_empty,
   input  logic                             rsp_pop,
   output logic [sepia_pkg::BYTE_W-1:0]     rsp_out_byte,
   output logic                             rsp_run_end,
   output logic                             rsp_frame_end,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [sepia_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [sepia_pkg::CSR_DATA_W-1:0] csr_data
);
   import sepia_pkg::*;

   csr_write_type    csr_wr;
   queue_status_type pixq_status;
   logic             pixq_push;
   logic             pixq_pop;
   pixel_type        pixq_data;
   pixel_type        pixq_head;

   assign csr_ready    = 1'b1;
   assign csr_wr.valid = csr_valid;
   assign csr_wr.index = csr_index;
   assign csr_wr.data  = csr_data;

   sepia_front u_front (
      .clock            (clock),
      .reset            (reset),
      .req_push         (req_push),
      .req_full         (req_full),
      .req_channel_byte (req_channel_byte),
      .csr_wr           (csr_wr),
      .pixq_status      (pixq_status),
      .pixq_push        (pixq_push),
      .pixq_data        (pixq_data)
   );

   sepia_pixq u_pixq (
      .clock     (clock),
      .reset     (reset),
      .push      (pixq_push),
      .push_data (pixq_data),
      .pop       (pixq_pop),
      .head      (pixq_head),
      .status    (pixq_status)
   );

   sepia_back u_back (
      .clock         (clock),
      .reset         (reset),
      .pixq_head     (pixq_head),
      .pixq_status   (pixq_status),
      .pixq_pop      (pixq_pop),
      .rsp_empty     (rsp_empty),
      .rsp_pop       (rsp_pop),
      .rsp_out_byte  (rsp_out_byte),
      .rsp_run_end   (rsp_run_end),
      .rsp_frame_end (rsp_frame_end)
   );

endmodule

// ===== rtl/sepia_checker.sv =====
// Port-level checks of the sepia tone byte stream core, bound to the top level.
module sepia_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             req_full,
   input logic                             rsp_empty,
   input logic                             rsp_pop,
   input logic [sepia_pkg::BYTE_W-1:0]     rsp_out_byte,
   input logic                             rsp_run_end,
   input logic                             rsp_frame_end
);
   import sepia_pkg::*;

   // Position of the next result within its pixel: zero for blue, one for green, two for red.
   logic [1:0] out_pos_ff, out_pos_in;
   logic       rsp_take;

   assign rsp_take = rsp_pop && !rsp_empty;

   always_comb begin
      out_pos_in = out_pos_ff;
      if (rsp_take) begin
         out_pos_in = (out_pos_ff == 2'd2) ? 2'd0 : out_pos_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_pos_ff <= 2'd0;
      end else begin
         out_pos_ff <= out_pos_in;
      end
   end

   a_reset_clears : assert property (@(posedge clock)
      reset |=> rsp_empty && !req_full)
      else $error("reset did not empty the result queue or left the request side full");

   a_rsp_hold : assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_pop) |=>
         (!rsp_empty && $stable(rsp_out_byte) && $stable(rsp_run_end)
          && $stable(rsp_frame_end)))
      else $error("waiting result changed before it was taken");

   a_run_end_third : assert property (@(posedge clock) disable iff (reset)
      !rsp_empty |-> (rsp_run_end == (out_pos_ff == 2'd2)))
      else $error("run end flag not on the third byte of a pixel");

   a_frame_end_on_red : assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_frame_end) |-> rsp_run_end)
      else $error("frame end flag on a byte other than red");

endmodule

bind sepia_tone_byte_stream_core sepia_checker u_sepia_checker (
   .clock         (clock),
   .reset         (reset),
   .req_full      (req_full),
   .rsp_empty     (rsp_empty),
   .rsp_pop       (rsp_pop),
   .rsp_out_byte  (rsp_out_byte),
   .rsp_run_end   (rsp_run_end),
   .rsp_frame_end (rsp_frame_end)
);
